// ----- hw/rtl/svhs_pkg.sv -----
// Shared types and codes for the servo head safety supervisor.
// Used by svhs_duty and servo_head_safety_supervisor; no dependencies.
package svhs_pkg;

  // Request codes; 9..14 are unknown and fall to a default arm
  typedef enum logic [3:0] {
    REQ_TICK     = 4'd0,
    REQ_PING     = 4'd1,
    REQ_STATUS   = 4'd2,
    REQ_ESTOP    = 4'd3,
    REQ_CLEAR    = 4'd4,
    REQ_CENTER   = 4'd5,
    REQ_MOVE     = 4'd6,
    REQ_LIGHT    = 4'd7,
    REQ_RESERVED = 4'd8,
    REQ_MISSING  = 4'd15
  } req_t;

  typedef enum logic [3:0] {
    ST_OK       = 4'd0,
    ST_TICK     = 4'd1,
    ST_BAD      = 4'd2,
    ST_ESTOP    = 4'd3,
    ST_LINK     = 4'd4,
    ST_CONFIRM  = 4'd5,
    ST_YAW      = 4'd6,
    ST_PITCH    = 4'd7,
    ST_RESERVED = 4'd8,
    ST_UNKNOWN  = 4'd9
  } status_t;

  typedef enum logic [2:0] {
    CFG_YAW_MIN   = 3'd0,
    CFG_YAW_MAX   = 3'd1,
    CFG_PITCH_MIN = 3'd2,
    CFG_PITCH_MAX = 3'd3,
    CFG_WARN      = 3'd4,
    CFG_STOP      = 3'd5
  } cfg_idx_t;

  typedef struct packed {
    logic               start;
    logic signed [15:0] yaw;
    logic signed [15:0] pitch;
  } duty_req_t;

  typedef struct packed {
    logic        done;
    logic [15:0] yaw_duty;
    logic [15:0] pitch_duty;
  } duty_rsp_t;

endpackage

// ----- hw/rtl/svhs_duty.sv -----
// PWM duty unit: turns the two stored angles into servo duty values.
// One shared multiplier, five steps per axis. Depends on svhs_pkg.
module svhs_duty #(
  parameter int DUTY_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  svhs_pkg::duty_req_t   req,
  output svhs_pkg::duty_rsp_t   rsp
);
  import svhs_pkg::*;

  // pulse*full-scale stays below 2000 * 2^DUTY_BITS
  localparam int PW  = DUTY_BITS + 11;
  localparam int KSH = PW;
  localparam int MBW = (DUTY_BITS > 16) ? DUTY_BITS : 16;
  localparam int PRW = PW + MBW;

  localparam logic [15:0] ANGLE_LIM  = 16'd9000;
  localparam logic [10:0] PULSE_BASE = 11'd1000;
  localparam logic [15:0] RECIP_18   = 16'd58255;   // ceil(2^20 / 18)
  localparam int          SHIFT_18   = 20;
  localparam logic [63:0] PERIOD_US  = 64'd20000;
  localparam logic [63:0] RECIP_PER  = (64'd1 << KSH) / PERIOD_US;
  localparam logic [63:0] FULL_SCALE = (64'd1 << DUTY_BITS) - 64'd1;

  localparam logic [2:0] STEP_DIV18  = 3'd0;
  localparam logic [2:0] STEP_SCALE  = 3'd1;
  localparam logic [2:0] STEP_RECIP  = 3'd2;
  localparam logic [2:0] STEP_BACK   = 3'd3;
  localparam logic [2:0] STEP_FIX    = 3'd4;

  typedef enum logic {D_IDLE, D_RUN} dstate_t;

  dstate_t            state;
  logic [2:0]         step;
  logic               axis;
  logic signed [15:0] yaw_in;
  logic signed [15:0] pitch_in;
  logic [PRW-1:0]     prod;
  logic [PW-1:0]      preg;
  logic [DUTY_BITS-1:0] qreg;
  logic               done;
  logic [15:0]        yaw_duty;
  logic [15:0]        pitch_duty;

  logic signed [15:0] ang;
  logic signed [15:0] clamped;
  logic signed [16:0] shifted;
  logic [14:0]        ang_u;
  logic [10:0]        pulse;
  logic [PW-1:0]      mul_a;
  logic [MBW-1:0]     mul_b;
  logic [PW-1:0]      rem;
  logic [31:0]        dwide;
  logic [15:0]        dsat;

  always_comb begin
    ang = axis ? pitch_in : yaw_in;
    if (ang > $signed(ANGLE_LIM)) begin
      clamped = $signed(ANGLE_LIM);
    end else if (ang < -$signed(ANGLE_LIM)) begin
      clamped = -$signed(ANGLE_LIM);
    end else begin
      clamped = ang;
    end
    // offset to 0..18000 so the divide by 18 is unsigned
    shifted = 17'(clamped) + 17'(ANGLE_LIM);
    ang_u   = shifted[14:0];
    pulse   = PULSE_BASE + 11'(prod[SHIFT_18 +: 10]);
  end

  always_comb begin
    case (step)
      STEP_DIV18: begin
        mul_a = PW'(ang_u);
        mul_b = MBW'(RECIP_18);
      end
      STEP_SCALE: begin
        mul_a = PW'(pulse);
        mul_b = MBW'(FULL_SCALE);
      end
      STEP_RECIP: begin
        mul_a = prod[PW-1:0];
        mul_b = MBW'(RECIP_PER);
      end
      STEP_BACK: begin
        mul_a = PW'(prod[KSH +: DUTY_BITS]);
        mul_b = MBW'(PERIOD_US);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // quotient estimate is at most one low; one compare fixes it
  always_comb begin
    rem   = preg - prod[PW-1:0];
    dwide = 32'(qreg) + 32'(rem >= PW'(PERIOD_US));
    dsat  = (dwide > 32'h0000_FFFF) ? 16'hFFFF : dwide[15:0];
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    if (rst) begin
      state <= D_IDLE;
      step  <= STEP_DIV18;
      axis  <= 1'b0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        D_IDLE: begin
          if (req.start) begin
            yaw_in   <= req.yaw;
            pitch_in <= req.pitch;
            step     <= STEP_DIV18;
            axis     <= 1'b0;
            state    <= D_RUN;
          end
        end
        D_RUN: begin
          if (step == STEP_RECIP) begin
            preg <= prod[PW-1:0];
          end
          if (step == STEP_BACK) begin
            qreg <= prod[KSH +: DUTY_BITS];
          end
          if (step == STEP_FIX) begin
            step <= STEP_DIV18;
            if (axis) begin
              pitch_duty <= dsat;
              done       <= 1'b1;
              state      <= D_IDLE;
            end else begin
              yaw_duty <= dsat;
              axis     <= 1'b1;
            end
          end else begin
            step <= step + 3'd1;
          end
        end
        default: state <= D_IDLE;
      endcase
    end
  end

  assign rsp.done       = done;
  assign rsp.yaw_duty   = yaw_duty;
  assign rsp.pitch_duty = pitch_duty;

endmodule

// ----- hw/rtl/servo_head_safety_supervisor.sv -----
// Servo head safety supervisor: one status item for every tick or command item.
// Depends on svhs_pkg and svhs_duty.
//
// Each item is a one-millisecond tick or a decoded command. The block keeps the
// emergency-stop, link-degraded, servo-enable and LED flags, the stored yaw and
// pitch angles and a saturating heartbeat age, and returns one result item per
// input item with the flags, angles, age and a PWM duty for each angle. The flags
// and angles update at the accepting edge; the result then passes through S_KICK,
// which starts the duty unit, then the duty unit (five passes of its single
// shared multiplier per axis), then the load of the output register. The next item
// is taken in the cycle after the result is loaded, even while that result still
// waits on out_stall; no item is taken before the last result is loaded. The user
// must make configuration writes only while idle; the block does not enforce it.
module servo_head_safety_supervisor #(
  parameter int DUTY_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  // configuration
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  // input items
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [3:0]  req_type,
  input  logic        yaw_present,
  input  logic signed [15:0] yaw_angle,
  input  logic        pitch_present,
  input  logic signed [15:0] pitch_angle,
  input  logic        operator_ok,
  input  logic [15:0] brightness,
  // result items
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  status,
  output logic        stop_active,
  output logic        link_stale,
  output logic        drive_on,
  output logic        led_on,
  output logic signed [15:0] yaw_now,
  output logic signed [15:0] pitch_now,
  output logic [15:0] yaw_duty,
  output logic [15:0] pitch_duty,
  output logic [31:0] beat_age
);
  import svhs_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_KICK, S_CALC, S_HOLD} state_t;

  localparam logic [15:0] LIGHT_THRESH = 16'd10;

  state_t state;

  logic signed [15:0] yaw_min;
  logic signed [15:0] yaw_max;
  logic signed [15:0] pitch_min;
  logic signed [15:0] pitch_max;
  logic [15:0]        warn_limit_ms;
  logic [15:0]        stop_limit_ms;

  logic               stop_flag, stale_flag, drive_flag, lamp_flag;
  logic signed [15:0] yaw_store, pitch_store;
  logic [31:0]        age_count;
  status_t            status_reg;

  logic               stop_next, stale_next, drive_next, lamp_next;
  logic signed [15:0] yaw_next, pitch_next;
  logic [31:0]        age_next;
  status_t            status_next;
  logic signed [15:0] yaw_try, pitch_try;

  duty_req_t duty_req;
  duty_rsp_t duty_rsp;

  logic in_take;
  logic out_free;
  logic load_out;

  assign in_stall = (state != S_IDLE);
  assign in_take  = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;
  assign load_out = out_free && ((state == S_CALC && duty_rsp.done) || state == S_HOLD);

  always_ff @(posedge clk) begin
    if (rst) begin
      yaw_min       <= -16'sd9000;
      yaw_max       <= 16'sd9000;
      pitch_min     <= -16'sd9000;
      pitch_max     <= 16'sd9000;
      warn_limit_ms <= 16'd1000;
      stop_limit_ms <= 16'd3000;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_YAW_MIN:   yaw_min       <= cfg_data;
        CFG_YAW_MAX:   yaw_max       <= cfg_data;
        CFG_PITCH_MIN: pitch_min     <= cfg_data;
        CFG_PITCH_MAX: pitch_max     <= cfg_data;
        CFG_WARN:      warn_limit_ms <= cfg_data;
        CFG_STOP:      stop_limit_ms <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    stop_next   = stop_flag;
    stale_next  = stale_flag;
    drive_next  = drive_flag;
    lamp_next   = lamp_flag;
    yaw_next    = yaw_store;
    pitch_next  = pitch_store;
    age_next    = age_count;
    status_next = ST_OK;
    yaw_try     = yaw_present ? yaw_angle : yaw_store;
    pitch_try   = pitch_present ? pitch_angle : pitch_store;

    if (req_type == REQ_TICK) begin
      if (age_count != 32'hFFFF_FFFF) begin
        age_next = age_count + 32'd1;
      end
      if (age_next > 32'(warn_limit_ms)) begin
        stale_next = 1'b1;
      end
      if (age_next > 32'(stop_limit_ms) && !stop_flag) begin
        drive_next = 1'b0;
        lamp_next  = 1'b1;
      end
      status_next = ST_TICK;
    end else begin
      // any command refreshes the heartbeat first
      age_next   = '0;
      stale_next = 1'b0;
      case (req_type) inside
        REQ_PING, REQ_STATUS: status_next = ST_OK;
        REQ_ESTOP: begin
          stop_next  = 1'b1;
          drive_next = 1'b0;
          lamp_next  = 1'b1;
        end
        REQ_CLEAR: begin
          if (!operator_ok) begin
            status_next = ST_CONFIRM;
          end else begin
            stop_next  = 1'b0;
            drive_next = 1'b1;
            lamp_next  = 1'b0;
          end
        end
        REQ_CENTER, REQ_MOVE: begin
          if (stop_flag) begin
            status_next = ST_ESTOP;
          end else if (stale_next) begin
            status_next = ST_LINK;
          end else if (req_type == REQ_CENTER) begin
            yaw_next   = '0;
            pitch_next = '0;
          end else if (yaw_try < yaw_min || yaw_try > yaw_max) begin
            status_next = ST_YAW;
          end else if (pitch_try < pitch_min || pitch_try > pitch_max) begin
            status_next = ST_PITCH;
          end else begin
            yaw_next   = yaw_try;
            pitch_next = pitch_try;
          end
        end
        REQ_LIGHT:    lamp_next   = (brightness > LIGHT_THRESH);
        REQ_RESERVED: status_next = ST_RESERVED;
        REQ_MISSING:  status_next = ST_BAD;
        default:      status_next = ST_UNKNOWN;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      stop_flag   <= 1'b0;
      stale_flag  <= 1'b0;
      drive_flag  <= 1'b1;
      lamp_flag   <= 1'b0;
      yaw_store   <= '0;
      pitch_store <= '0;
      age_count   <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (load_out) begin
        out_valid    <= 1'b1;
        status       <= status_reg;
        stop_active  <= stop_flag;
        link_stale   <= stale_flag;
        drive_on     <= drive_flag;
        led_on       <= lamp_flag;
        yaw_now      <= yaw_store;
        pitch_now    <= pitch_store;
        yaw_duty     <= duty_rsp.yaw_duty;
        pitch_duty   <= duty_rsp.pitch_duty;
        beat_age     <= age_count;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_take) begin
            stop_flag   <= stop_next;
            stale_flag  <= stale_next;
            drive_flag  <= drive_next;
            lamp_flag   <= lamp_next;
            yaw_store   <= yaw_next;
            pitch_store <= pitch_next;
            age_count   <= age_next;
            status_reg  <= status_next;
            state       <= S_KICK;
          end
        end
        S_KICK: state <= S_CALC;
        S_CALC: begin
          if (duty_rsp.done) begin
            state <= load_out ? S_IDLE : S_HOLD;
          end
        end
        S_HOLD: begin
          if (load_out) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign duty_req.start = (state == S_KICK);
  assign duty_req.yaw   = yaw_store;
  assign duty_req.pitch = pitch_store;

  svhs_duty #(
    .DUTY_BITS(DUTY_BITS)
  ) u_duty (
    .clk (clk),
    .rst (rst),
    .req (duty_req),
    .rsp (duty_rsp)
  );

endmodule
